[hdl/abs_pkg.sv]
// ----------------------------------------------------------------------------
// abs_pkg
// Shared constants and types of the average background subtractor.
// ----------------------------------------------------------------------------
package abs_pkg;

    localparam int PIXELS     = 65536;
    localparam int MAX_FRAMES = 1024;

    localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int FRAME_W   = $clog2(MAX_FRAMES + 1);
    localparam int SUM_LIMIT = 255 * MAX_FRAMES;
    localparam int SUM_W     = $clog2(SUM_LIMIT + 1);
    localparam int DIVD_W    = SUM_W + 4;
    localparam int DIFF_W    = DIVD_W + 1;
    localparam int PROD_W    = DIFF_W + 8;
    localparam int SHIFT_W   = PROD_W - 4;
    localparam int BOUND_W   = PROD_W - 2;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);
    localparam int LANES     = 6;

    localparam logic [1:0] CMD_LEARN  = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_DETECT = 2'd2;

    localparam logic REG_HIGH_SCALE = 1'b0;
    localparam logic REG_LOW_SCALE  = 1'b1;

    localparam logic [7:0] HIGH_SCALE_RST = 8'd112;
    localparam logic [7:0] LOW_SCALE_RST  = 8'd96;

    typedef struct packed {
        logic [2:0][SUM_W-1:0]   vsum;
        logic [2:0][SUM_W-1:0]   dsum;
        logic [2:0][7:0]         prev;
        logic [2:0][BOUND_W-1:0] low;
        logic [2:0][BOUND_W-1:0] high;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

endpackage

[hdl/abs_ram.sv]
// ----------------------------------------------------------------------------
// abs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module abs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/abs_div.sv]
// ----------------------------------------------------------------------------
// abs_div
// Restoring divider lane, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [abs_pkg::DIVD_W-1:0]  dividend,
    input  logic [abs_pkg::FRAME_W-1:0] divisor,
    output logic                        busy,
    output logic [abs_pkg::DIVD_W-1:0]  quotient
);
    import abs_pkg::*;

    logic [DIVD_W-1:0]  dvd_reg, dvd_next;
    logic [FRAME_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [FRAME_W:0]   shifted;
    logic               qbit;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[DIVD_W-1]};
        qbit      = (shifted >= {1'b0, divisor});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = DCNT_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? FRAME_W'(shifted - {1'b0, divisor}) : FRAME_W'(shifted);
            dvd_next = {dvd_reg[DIVD_W-2:0], qbit};
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

[hdl/average_background_subtractor_top.sv]
// ----------------------------------------------------------------------------
// average_background_subtractor_top
// Per-pixel running-average background model with learn, build and detect.
// ----------------------------------------------------------------------------
// Learn and detect items read the RAM, then update or compare in the EXEC state.
// Build items read the RAM, then run the bit-serial dividers and the MUL and WRITE states.
// Detect results sit in an output register; the next item is taken meanwhile.
// After reset a clearing pass writes every one of the PIXELS (65536) entries
// before the first item is accepted; configuration writes are taken throughout.
module average_background_subtractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_pixel_addr,
    input  logic        s_frame_start,
    input  logic [7:0]  s_chan_a,
    input  logic [7:0]  s_chan_b,
    input  logic [7:0]  s_chan_c,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_foreground,
    output logic [15:0] m_result_addr
);
    import abs_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]         high_scale_reg, low_scale_reg;
    logic [FRAME_W-1:0] frames_reg;
    logic               started_reg, accum_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic [1:0]         cmd_reg;
    logic [15:0]        addr_reg;
    logic               addr_ok_reg;
    logic [2:0][7:0]    px_reg;

    logic               m_valid_reg;
    logic               m_fg_reg;
    logic [15:0]        m_addr_reg;

    logic [2:0][DIVD_W-1:0]  avg_reg;
    logic [2:0][SHIFT_W-1:0] up_reg, dn_reg;

    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata, rd_entry, learn_entry, build_entry;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [FRAME_W-1:0]           divisor;
    logic [LANES-1:0][DIVD_W-1:0] dividends, quots;
    logic [LANES-1:0]             busys;
    logic                         div_start;

    logic [2:0][SHIFT_W-1:0] up_c, dn_c;
    logic                    in_range;
    logic                    detect_fg;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign rd_entry = entry_t'(ram_rdata);
    assign divisor  = (frames_reg == '0) ? FRAME_W'(1) : frames_reg;

    abs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PIXELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ADDR_W'(s_pixel_addr)),
        .rdata (ram_rdata)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_div
        abs_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (dividends[l]),
            .divisor  (divisor),
            .busy     (busys[l]),
            .quotient (quots[l])
        );
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dividends[c]     = DIVD_W'({rd_entry.vsum[c], 4'b0000}) + DIVD_W'(divisor >> 1);
            dividends[c + 3] = DIVD_W'({rd_entry.dsum[c], 4'b0000}) + DIVD_W'(divisor >> 1);
        end
    end

    // learn update
    always_comb begin
        logic [7:0]       d;
        logic [SUM_W:0]   sv, sd;
        learn_entry = rd_entry;
        for (int c = 0; c < 3; c++) begin
            d  = (px_reg[c] > rd_entry.prev[c]) ? px_reg[c] - rd_entry.prev[c]
                                                : rd_entry.prev[c] - px_reg[c];
            sv = {1'b0, rd_entry.vsum[c]} + (SUM_W + 1)'(px_reg[c]);
            sd = {1'b0, rd_entry.dsum[c]} + (SUM_W + 1)'(d);
            if (accum_reg) begin
                learn_entry.vsum[c] = (sv > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT)
                                                                     : SUM_W'(sv);
                learn_entry.dsum[c] = (sd > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT)
                                                                     : SUM_W'(sd);
            end
            learn_entry.prev[c] = px_reg[c];
        end
    end

    // scaled mean difference
    always_comb begin
        logic [DIFF_W-1:0] diff;
        logic [PROD_W-1:0] pu, pd;
        for (int c = 0; c < 3; c++) begin
            diff    = DIFF_W'(quots[c + 3]) + DIFF_W'(16);
            pu      = PROD_W'(high_scale_reg) * PROD_W'(diff) + PROD_W'(8);
            pd      = PROD_W'(low_scale_reg) * PROD_W'(diff) + PROD_W'(8);
            up_c[c] = pu[PROD_W-1:4];
            dn_c[c] = pd[PROD_W-1:4];
        end
    end

    always_comb begin
        build_entry = rd_entry;
        for (int c = 0; c < 3; c++) begin
            build_entry.high[c] = BOUND_W'(avg_reg[c]) + BOUND_W'(up_reg[c]);
            build_entry.low[c]  = BOUND_W'(avg_reg[c]) - BOUND_W'(dn_reg[c]);
        end
    end

    always_comb begin
        logic signed [BOUND_W-1:0] v;
        in_range = 1'b0;
        for (int c = 0; c < 3; c++) begin
            v = BOUND_W'({px_reg[c], 4'b0000});
            if (v >= $signed(rd_entry.low[c]) && v < $signed(rd_entry.high[c])) begin
                in_range = 1'b1;
            end
        end
        detect_fg = addr_ok_reg && !in_range;
    end

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(addr_reg);
        ram_wdata  = learn_entry;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == ADDR_W'(PIXELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_LEARN: begin
                        ram_we = addr_ok_reg;
                    end
                    CMD_BUILD: begin
                        if (addr_ok_reg) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    CMD_DETECT: begin
                        if (!out_free) begin
                            state_next = ST_EXEC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIV: begin
                if (busys == '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                ram_we     = 1'b1;
                ram_wdata  = build_entry;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            high_scale_reg <= HIGH_SCALE_RST;
            low_scale_reg  <= LOW_SCALE_RST;
            frames_reg     <= '0;
            started_reg    <= 1'b0;
            accum_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_HIGH_SCALE: high_scale_reg <= cfg_wr_data;
                    REG_LOW_SCALE:  low_scale_reg  <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (accept && s_cmd == CMD_LEARN && s_frame_start) begin
                if (started_reg) begin
                    if (frames_reg < FRAME_W'(MAX_FRAMES)) begin
                        frames_reg <= frames_reg + FRAME_W'(1);
                        accum_reg  <= 1'b1;
                    end else begin
                        accum_reg  <= 1'b0;
                    end
                end
                started_reg <= 1'b1;
            end
            if (state_reg == ST_EXEC && cmd_reg == CMD_DETECT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            cmd_reg     <= s_cmd;
            addr_reg    <= s_pixel_addr;
            addr_ok_reg <= (32'(s_pixel_addr) < PIXELS);
            px_reg      <= {s_chan_c, s_chan_b, s_chan_a};
        end
        if (state_reg == ST_EXEC && cmd_reg == CMD_DETECT && out_free) begin
            m_fg_reg   <= detect_fg;
            m_addr_reg <= addr_reg;
        end
        if (state_reg == ST_MUL) begin
            for (int c = 0; c < 3; c++) begin
                avg_reg[c] <= quots[c];
            end
            up_reg <= up_c;
            dn_reg <= dn_c;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_foreground  = m_fg_reg;
    assign m_result_addr = m_addr_reg;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the average background subtractor: learns frames
// over a small set of pixels, builds bounds, detects, and compares every
// foreground result with a behavioral model of the pixel statistics.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import abs_pkg::*;

    localparam int NPIX = 8;
    localparam int FRAME_CAP = 6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_HIGH_SCALE;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_LEARN;
    logic [15:0] s_pixel_addr = '0;
    logic        s_frame_start = 1'b0;
    logic [7:0]  s_chan_a = '0;
    logic [7:0]  s_chan_b = '0;
    logic [7:0]  s_chan_c = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_foreground;
    logic [15:0] m_result_addr;

    average_background_subtractor_top u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic        fs;
        logic [7:0]  a, b, c;
        int          want_fg;   // -1: use model
    } pix_item_t;

    typedef struct {
        logic        fg;
        logic [15:0] addr;
    } fg_result_t;

    // model state
    int unsigned   hi_scale, lo_scale, frame_cnt;
    bit            seen_start, accum;
    int unsigned   vsum[int][3], dsum[int][3];
    int unsigned   prev_px[int][3];
    longint        lo_b[int][3], hi_b[int][3];
    fg_result_t    fg_expected[$];

    int  errors = 0, n_items = 0, n_results = 0, n_fg = 0;
    bit  quiet = 0, drain = 0;

    function automatic int unsigned q4_avg(int unsigned s, int unsigned n);
        return int'(((longint'(s) << 4) + (n >> 1)) / n);
    endfunction

    task automatic model_item(pix_item_t it);
        int unsigned px[3];
        int unsigned n, d, df;
        longint av, v;
        bit in_rng;
        fg_result_t r;
        px = '{it.a, it.b, it.c};
        case (it.cmd)
            CMD_LEARN: begin
                if (it.fs) begin
                    if (seen_start) begin
                        if (frame_cnt < MAX_FRAMES) begin
                            frame_cnt++;
                            accum = 1;
                        end else begin
                            accum = 0;
                        end
                    end
                    seen_start = 1;
                end
                if (!vsum.exists(it.addr))
                    for (int c = 0; c < 3; c++) begin
                        vsum[it.addr][c] = 0;
                        dsum[it.addr][c] = 0;
                    end
                for (int c = 0; c < 3; c++) begin
                    if (accum) begin
                        d = px[c] > prev_px[it.addr][c] ? px[c] - prev_px[it.addr][c]
                                                        : prev_px[it.addr][c] - px[c];
                        vsum[it.addr][c] = (vsum[it.addr][c] + px[c] > SUM_LIMIT)
                            ? SUM_LIMIT : vsum[it.addr][c] + px[c];
                        dsum[it.addr][c] = (dsum[it.addr][c] + d > SUM_LIMIT)
                            ? SUM_LIMIT : dsum[it.addr][c] + d;
                    end
                    prev_px[it.addr][c] = px[c];
                end
            end
            CMD_BUILD: begin
                n = frame_cnt ? frame_cnt : 1;
                for (int c = 0; c < 3; c++) begin
                    av = vsum.exists(it.addr) ? q4_avg(vsum[it.addr][c], n) : 0;
                    df = (dsum.exists(it.addr) ? q4_avg(dsum[it.addr][c], n) : 0) + 16;
                    hi_b[it.addr][c] = av + ((longint'(hi_scale) * df + 8) >> 4);
                    lo_b[it.addr][c] = av - ((longint'(lo_scale) * df + 8) >> 4);
                end
            end
            CMD_DETECT: begin
                in_rng = 0;
                for (int c = 0; c < 3; c++) begin
                    v = longint'(px[c]) << 4;
                    if (v >= lo_b[it.addr][c] && v < hi_b[it.addr][c]) in_rng = 1;
                end
                r.fg = !in_rng;
                r.addr = it.addr;
                if (it.want_fg >= 0 && r.fg !== it.want_fg[0]) begin
                    $error("table foreground: expected %0d, model %0d", it.want_fg, r.fg);
                    errors++;
                end
                fg_expected.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_HIGH_SCALE) hi_scale = val; else lo_scale = val;
    endtask

    task automatic send_pixel(pix_item_t it);
        if (!quiet && !drain && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd; s_pixel_addr <= it.addr; s_frame_start <= it.fs;
        s_chan_a <= it.a; s_chan_b <= it.b; s_chan_c <= it.c;
        do @(posedge aclk); while (!s_ready);
        model_item(it);
        n_items++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (fg_expected.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic pix_item_t mk(logic [1:0] cmd, int addr, bit fs,
                                     int a, int b, int c, int want = -1);
        pix_item_t it;
        it.cmd = cmd; it.addr = addr; it.fs = fs;
        it.a = a; it.b = b; it.c = c; it.want_fg = want;
        return it;
    endfunction

    function automatic pix_item_t rnd_learn(int addr, bit fs);
        return mk(CMD_LEARN, addr, fs, $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fg_expected.size() == 0) begin
                $error("unexpected result at addr %0h", m_result_addr);
                errors++;
            end else begin
                fg_result_t r;
                r = fg_expected.pop_front();
                if (m_foreground !== r.fg) begin
                    $error("foreground: expected %0d, got %0d", r.fg, m_foreground);
                    errors++;
                end
                if (m_result_addr !== r.addr) begin
                    $error("result_addr: expected %0h, got %0h", r.addr, m_result_addr);
                    errors++;
                end
                n_results++;
                n_fg += r.fg;
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (drain || quiet) m_ready <= 1'b1;
            else if (stall > 0) begin
                m_ready <= 1'b0; stall--;
            end else if ($urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 9); m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    task automatic learn_pass(int frames, int maxv, bit full);
        for (int f = 0; f < frames; f++)
            for (int p = 0; p < NPIX; p++)
                send_pixel(full ? rnd_learn(p, p == 0)
                                : mk(CMD_LEARN, p, p == 0, $urandom_range(0, maxv),
                                     $urandom_range(0, maxv), $urandom_range(0, maxv)));
    endtask

    initial begin
        pix_item_t table_rows[$];
        pix_item_t it;
        int unsigned sc;
        hi_scale = HIGH_SCALE_RST; lo_scale = LOW_SCALE_RST;
        frame_cnt = 0; seen_start = 0; accum = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: priming frame with extremes, one accumulated frame, builds, detects
        table_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, 0));          // no frames yet
        table_rows.push_back(mk(CMD_DETECT, 0, 0, 0, 0, 0, 0));      // avg 0 in range
        table_rows.push_back(mk(CMD_DETECT, 0, 0, 255, 255, 255, 1));
        table_rows.push_back(mk(CMD_LEARN, 1, 0, 9, 9, 9));          // before first start
        table_rows.push_back(mk(CMD_LEARN, 0, 1, 0, 0, 0));
        table_rows.push_back(mk(CMD_LEARN, 1, 0, 255, 255, 255));
        table_rows.push_back(mk(CMD_LEARN, 2, 0, 8'haa, 8'h55, 8'hff));
        table_rows.push_back(mk(CMD_LEARN, 16'hffff, 0, 1, 2, 3));
        table_rows.push_back(mk(2'd3, 5, 1, 7, 7, 7));               // unused command
        table_rows.push_back(mk(CMD_LEARN, 0, 1, 255, 255, 255));
        table_rows.push_back(mk(CMD_LEARN, 1, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_LEARN, 2, 0, 8'h55, 8'haa, 8'h00));
        table_rows.push_back(mk(CMD_LEARN, 16'hffff, 0, 255, 0, 255));
        table_rows.push_back(mk(CMD_BUILD, 0, 1, 0, 0, 0));
        table_rows.push_back(mk(CMD_BUILD, 1, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_BUILD, 2, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_BUILD, 16'hffff, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_DETECT, 0, 1, 0, 0, 0));
        table_rows.push_back(mk(CMD_DETECT, 0, 0, 255, 255, 255));
        table_rows.push_back(mk(CMD_DETECT, 1, 0, 128, 0, 255));
        table_rows.push_back(mk(CMD_DETECT, 2, 0, 8'h55, 8'haa, 8'h00));
        table_rows.push_back(mk(CMD_DETECT, 16'hffff, 0, 255, 255, 255));
        table_rows.push_back(mk(CMD_DETECT, 16'hffff, 0, 0, 0, 0));
        foreach (table_rows[i]) send_pixel(table_rows[i]);
        wait_idle();

        // random phases through several scale settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_HIGH_SCALE, 8'd0);   write_reg(REG_LOW_SCALE, 8'd255); end
                1: begin write_reg(REG_HIGH_SCALE, 8'd255); write_reg(REG_LOW_SCALE, 8'd0);   end
                2: begin write_reg(REG_HIGH_SCALE, 8'd16);  write_reg(REG_LOW_SCALE, 8'd16);  end
                default: begin
                    sc = $urandom_range(0, 255); write_reg(REG_HIGH_SCALE, 8'(sc));
                    sc = $urandom_range(0, 255); write_reg(REG_LOW_SCALE, 8'(sc));
                end
            endcase
            if (ph == 5) quiet = 1;
            learn_pass($urandom_range(1, FRAME_CAP), 255, 1);
            for (int p = 0; p < NPIX; p++) send_pixel(mk(CMD_BUILD, p, 0, 0, 0, 0));
            for (int k = 0; k < 120; k++) begin
                case ($urandom_range(0, 9))
                    0: it = mk(CMD_LEARN, $urandom_range(0, NPIX - 1), 0,
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
                    1: it = mk(CMD_BUILD, $urandom_range(0, NPIX - 1), $urandom_range(0, 1),
                               0, 0, 0);
                    2: it = mk(2'd3, $urandom, $urandom_range(0, 1), $urandom, $urandom,
                               $urandom);
                    3: it = mk(CMD_DETECT, 16'hffff, $urandom_range(0, 1),
                               $urandom, $urandom, $urandom);
                    default: it = mk(CMD_DETECT, $urandom_range(0, NPIX - 1),
                                     $urandom_range(0, 1), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 255));
                endcase
                send_pixel(it);
            end
            if (ph == 2) wait_idle();
            if (ph < 5) wait_idle();
        end
        drain = 1;
        wait_idle();
        $display("Covered %0d items, %0d detect results (%0d foreground), %0d frames.",
                 n_items, n_results, n_fg, frame_cnt);
        if (errors == 0) $display("[average_background_subtractor_top] OK");
        else $display("[average_background_subtractor_top] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[average_background_subtractor_top] ERROR");
        $finish;
    end
endmodule
